/* sv/lcdseq_pkg.sv */
package lcdseq_pkg;

  // Request codes carried on the action field.
  typedef enum logic [3:0] {
    ACT_DATA      = 4'd0,
    ACT_SETCURSOR = 4'd1,
    ACT_CLEAR     = 4'd2,
    ACT_HOME      = 4'd3,
    ACT_DISPLAY   = 4'd4,
    ACT_CURSOR    = 4'd5,
    ACT_BLINK     = 4'd6,
    ACT_SCROLL    = 4'd7,
    ACT_ENTRYDIR  = 4'd8,
    ACT_BACKLIGHT = 4'd9,
    ACT_CGRAMADDR = 4'd10,
    ACT_INIT      = 4'd11
  } action_t;

  // Configuration register indexes.
  localparam logic REG_NUM_ROWS  = 1'b0;
  localparam logic REG_TALL_FONT = 1'b1;

  // Kinds of work handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_BYTE   = 2'd0,
    JOB_SINGLE = 2'd1,
    JOB_INIT   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  value;  // byte to send, or function set byte for init
    logic        rs;     // register select
    logic        bl;     // backlight bit for every write of this job
    logic        extra;  // long wait after the last write (clear and home)
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // Display commands.
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_ENTRY      = 8'h04;
  localparam logic [7:0] CMD_DISPCTRL   = 8'h08;
  localparam logic [7:0] CMD_SCROLL_L   = 8'h18;
  localparam logic [7:0] CMD_SCROLL_R   = 8'h1C;
  localparam logic [7:0] CMD_FUNCSET    = 8'h20;
  localparam logic [7:0] CMD_CGRAM      = 8'h40;
  localparam logic [7:0] CMD_DDRAM      = 8'h80;
  localparam logic [7:0] FS_TWO_LINE    = 8'h08;
  localparam logic [7:0] FS_TALL_FONT   = 8'h04;
  localparam logic [2:0] FLAGS_RESET    = 3'b100;

  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

  // Wait times in microseconds.
  localparam logic [15:0] WAIT_POWER_UP  = 16'd50000;
  localparam logic [16:0] WAIT_EN_HIGH   = 17'd1;
  localparam logic [16:0] WAIT_EN_LOW    = 17'd50;
  localparam logic [16:0] WAIT_WAKE_LONG = 17'd5000;
  localparam logic [16:0] WAIT_WAKE_SHORT= 17'd1000;
  localparam logic [16:0] WAIT_CLEAR     = 17'd2000;
  localparam logic [16:0] WAIT_INIT_DONE = 17'd100000;

  localparam logic [3:0] INIT_LAST_NIB  = 4'd11;

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // Nibble number idx of the init sequence; fs is the function set byte.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx, input logic [7:0] fs);
    logic [3:0] n;
    case (idx)
      4'd0, 4'd1, 4'd2: n = NIB_WAKE;
      4'd3:             n = NIB_FOUR_BIT;
      4'd4:             n = fs[7:4];
      4'd5:             n = fs[3:0];
      4'd6:             n = CMD_DISPCTRL[7:4];
      4'd7:             n = CMD_DISPCTRL[3:0] | {1'b0, FLAGS_RESET};
      4'd8:             n = CMD_CLEAR[7:4];
      4'd9:             n = CMD_CLEAR[3:0];
      4'd10:            n = CMD_ENTRY[7:4];
      default:          n = CMD_ENTRY[3:0] | 4'h2;
    endcase
    return n;
  endfunction

endpackage

/* sv/lcdseq_front.sv */
module lcdseq_front import lcdseq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  input  logic        in_flag,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [2:0] num_rows_r;
  logic       tall_font_r;
  logic [2:0] flags_r, flags_nxt;
  logic       entry_left_r, entry_left_nxt;
  logic       backlight_r, backlight_nxt;

  logic       accept;
  logic       known;
  logic [2:0] rows;
  logic [1:0] row_c;
  logic [7:0] fs;
  job_t       job;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    rows  = (num_rows_r == 3'd0) ? 3'd1 : num_rows_r;
    row_c = ({1'b0, in_row} >= rows) ? 2'(rows - 3'd1) : in_row;
    fs    = CMD_FUNCSET
          | ((num_rows_r > 3'd1) ? FS_TWO_LINE : 8'h00)
          | ((tall_font_r && num_rows_r == 3'd1) ? FS_TALL_FONT : 8'h00);
  end

  always_comb begin
    flags_nxt      = flags_r;
    entry_left_nxt = entry_left_r;
    backlight_nxt  = backlight_r;
    known          = 1'b1;
    job.kind       = JOB_BYTE;
    job.value      = 8'h00;
    job.rs         = 1'b0;
    job.extra      = 1'b0;
    unique case (action_t'(in_action))
      ACT_DATA: begin
        job.value = in_data_byte;
        job.rs    = 1'b1;
      end
      ACT_SETCURSOR: job.value = CMD_DDRAM | ({2'b00, in_column} + row_base(row_c));
      ACT_CLEAR: begin
        job.value = CMD_CLEAR;
        job.extra = 1'b1;
      end
      ACT_HOME: begin
        job.value = CMD_HOME;
        job.extra = 1'b1;
      end
      ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: begin
        if (action_t'(in_action) == ACT_DISPLAY) flags_nxt[2] = in_flag;
        else if (action_t'(in_action) == ACT_CURSOR) flags_nxt[1] = in_flag;
        else flags_nxt[0] = in_flag;
        job.value = CMD_DISPCTRL | {5'b0, flags_nxt};
      end
      ACT_SCROLL: job.value = in_flag ? CMD_SCROLL_L : CMD_SCROLL_R;
      ACT_ENTRYDIR: begin
        entry_left_nxt = in_flag;
        job.value      = CMD_ENTRY | {6'b0, in_flag, 1'b0};
      end
      ACT_BACKLIGHT: begin
        backlight_nxt = in_flag;
        job.kind      = JOB_SINGLE;
      end
      ACT_CGRAMADDR: job.value = CMD_CGRAM | {2'b00, in_data_byte[2:0], 3'b000};
      ACT_INIT: begin
        flags_nxt      = FLAGS_RESET;
        entry_left_nxt = 1'b1;
        backlight_nxt  = 1'b1;
        job.kind       = JOB_INIT;
        job.value      = fs;
      end
      default: known = 1'b0;
    endcase
    job.bl = backlight_nxt;
  end

  assign q_push = accept && known;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r   <= 3'd2;
      tall_font_r  <= 1'b0;
      flags_r      <= FLAGS_RESET;
      entry_left_r <= 1'b1;
      backlight_r  <= 1'b1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_ROWS) num_rows_r <= cfg_wdata;
        else tall_font_r <= cfg_wdata[0];
      end
      if (accept) begin
        flags_r      <= flags_nxt;
        entry_left_r <= entry_left_nxt;
        backlight_r  <= backlight_nxt;
      end
    end
  end

endmodule

/* sv/lcdseq_queue.sv */
module lcdseq_queue import lcdseq_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

/* sv/lcdseq_back.sv */
module lcdseq_back import lcdseq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_expander_byte,
  output logic [15:0] out_wait_before_us,
  output logic [16:0] out_wait_after_us,
  output logic        out_last
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [3:0]  nib_r;
  logic [1:0]  phase_r;

  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic [15:0] before_r;
  logic [16:0] after_r;
  logic        last_r;

  logic        out_free;
  logic        emit;
  logic        last_w;
  logic        load;
  logic [3:0]  nib_val;
  logic [7:0]  byte_w;
  logic [15:0] before_w;
  logic [16:0] after_w;
  logic [16:0] extra_w;

  assign out_free = !out_valid_r || !out_stall;

  // Which write of the job is current, and what it carries.
  always_comb begin
    unique case (job_r.kind)
      JOB_INIT:   last_w = (nib_r == INIT_LAST_NIB) && (phase_r == 2'd2);
      JOB_SINGLE: last_w = 1'b1;
      default:    last_w = nib_r[0] && (phase_r == 2'd2);
    endcase

    nib_val = (job_r.kind == JOB_INIT) ? init_nibble(nib_r, job_r.value)
            : (nib_r[0] ? job_r.value[3:0] : job_r.value[7:4]);

    if (job_r.kind == JOB_SINGLE) byte_w = {4'h0, job_r.bl, 3'b000};
    else byte_w = {nib_val, job_r.bl, (phase_r == 2'd1), 1'b0, job_r.rs};

    before_w = (job_r.kind == JOB_INIT && nib_r == 4'd0 && phase_r == 2'd0)
             ? WAIT_POWER_UP : 16'd0;

    extra_w = 17'd0;
    if (phase_r == 2'd2) begin
      if (job_r.kind == JOB_INIT) begin
        case (nib_r)
          4'd0, 4'd1: extra_w = WAIT_WAKE_LONG;
          4'd2:       extra_w = WAIT_WAKE_SHORT;
          4'd9:       extra_w = WAIT_CLEAR;
          4'd11:      extra_w = WAIT_INIT_DONE;
          default:    extra_w = 17'd0;
        endcase
      end else if (job_r.kind == JOB_BYTE && job_r.extra && nib_r[0]) begin
        extra_w = WAIT_CLEAR;
      end
    end

    if (job_r.kind == JOB_SINGLE) after_w = 17'd0;
    else begin
      case (phase_r)
        2'd1:    after_w = WAIT_EN_HIGH + extra_w;
        2'd2:    after_w = WAIT_EN_LOW + extra_w;
        default: after_w = extra_w;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_RUN;
      BK_RUN:  if (out_free && last_w && q_empty) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    emit = 1'b0;
    load = 1'b0;
    unique case (state_r)
      BK_IDLE: load = !q_empty;
      BK_RUN: begin
        emit = out_free;
        load = out_free && last_w && !q_empty;
      end
      default: ;
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      nib_r       <= 4'd0;
      phase_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (load) begin
        nib_r   <= 4'd0;
        phase_r <= 2'd0;
      end else if (emit) begin
        if (phase_r == 2'd2) begin
          phase_r <= 2'd0;
          nib_r   <= nib_r + 4'd1;
        end else begin
          phase_r <= phase_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= q_head;
    if (emit) begin
      byte_r   <= byte_w;
      before_r <= before_w;
      after_r  <= after_w;
      last_r   <= last_w;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_expander_byte  = byte_r;
  assign out_wait_before_us = before_r;
  assign out_wait_after_us  = after_r;
  assign out_last           = last_r;

endmodule

/* sv/lcd_i2c_nibble_command_sequencer_top.sv */
// Sequencer for a 4-bit character LCD behind an I2C port expander.
// The request channel (in_valid / in_stall) takes one display request:
// an action code with its data byte, cursor column and row, and an on/off
// flag. The result channel (out_valid / out_stall) gives the expander byte
// writes that the request causes, each with the pause the bus master must
// keep before and after it, and out_last marks the final write of a request.
// A data byte or a command yields six writes, a backlight change one write,
// init thirty-six writes; unknown action codes are taken and dropped.
// The back end produces one write per cycle while the output is not stalled,
// and queued requests follow each other with no gap. A taken request is
// written into the request queue, then loaded into the sequencer, and its
// first write is then captured in the output register. The queue holds
// QUEUE_DEPTH classified requests; in_stall is raised only while it is
// full, so a stalled output still lets requests in.
// When the receiver stalls, the output register holds its write unchanged
// and the sequencer waits. Reset clears the queue and output, sets two rows,
// normal font, display on with cursor and blink off, left-to-right entry
// and backlight on. The user must write configuration (cfg_we, cfg_index,
// cfg_wdata) only while no request is in flight; the block does not enforce it.
module lcd_i2c_nibble_command_sequencer_top import lcdseq_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  input  logic        in_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_expander_byte,
  output logic [15:0] out_wait_before_us,
  output logic [16:0] out_wait_after_us,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);

  // The front decodes each request into a job and updates the shadow flags.
  logic q_push, q_pop, q_full, q_empty;
  job_t q_job, q_head;

  lcdseq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .in_column    (in_column),
    .in_row       (in_row),
    .in_flag      (in_flag),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // The queue decouples request intake from write generation.
  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // The back walks each job's nibbles and enable phases, one write per cycle unless the output stalls.
  lcdseq_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_expander_byte  (out_expander_byte),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

endmodule
